// ===== hdl/ppor_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and lookup functions shared by the coordinate rank/unrank pipeline.
package ppor_pkg;

    localparam int PIECES      = 6;
    localparam int VAL_W       = 29;
    localparam int MAGIC_SHIFT = 33;

    localparam logic REQ_RANK   = 1'b0;
    localparam logic REQ_UNRANK = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PIECE_COUNT = 2'd0;
    localparam logic [1:0] CFG_ORIENT      = 2'd1;
    localparam logic [1:0] CFG_LARGE       = 2'd2;

    typedef struct packed {
        logic                   req_type;
        logic [VAL_W-1:0]       index_in;
        logic [5:0]             in_piece_0;
        logic [5:0]             in_piece_1;
        logic [5:0]             in_piece_2;
        logic [5:0]             in_piece_3;
        logic [5:0]             in_piece_4;
        logic [5:0]             in_piece_5;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0]       index_out;
        logic [5:0]             out_piece_0;
        logic [5:0]             out_piece_1;
        logic [5:0]             out_piece_2;
        logic [5:0]             out_piece_3;
        logic [5:0]             out_piece_4;
        logic [5:0]             out_piece_5;
        logic                   error;
    } rsp_t;

    // Effective configuration after clamping.
    typedef struct packed {
        logic [2:0]             n;
        logic [1:0]             c;
        logic [3:0]             npos;
        logic [VAL_W-1:0]       space;
    } cfg_t;

    // Item state carried down the pipeline.
    typedef struct packed {
        logic                   unrank;
        logic                   err;
        logic [VAL_W-1:0]       val;
        logic [VAL_W-1:0]       rank_idx;
        logic [PIECES-1:0][1:0] ori;
        logic [PIECES-1:0][3:0] dig;
        logic [11:0]            used;
    } work_t;

    // Lehmer digit weight: product of (N - j) for j below i.
    function automatic logic [16:0] lehmer_weight(input logic big, input logic [2:0] i);
        logic [16:0] w;
        w = 17'd1;
        if (big) begin
            case (i)
                3'd1:    w = 17'd12;
                3'd2:    w = 17'd132;
                3'd3:    w = 17'd1320;
                3'd4:    w = 17'd11880;
                3'd5:    w = 17'd95040;
                default: w = 17'd1;
            endcase
        end else begin
            case (i)
                3'd1:    w = 17'd8;
                3'd2:    w = 17'd56;
                3'd3:    w = 17'd336;
                3'd4:    w = 17'd1680;
                3'd5:    w = 17'd6720;
                default: w = 17'd1;
            endcase
        end
        return w;
    endfunction

    // N! / (N - n)! for n in 1..6.
    function automatic logic [19:0] perm_space(input logic big, input logic [2:0] n);
        logic [19:0] s;
        s = 20'd1;
        if (big) begin
            case (n)
                3'd1:    s = 20'd12;
                3'd2:    s = 20'd132;
                3'd3:    s = 20'd1320;
                3'd4:    s = 20'd11880;
                3'd5:    s = 20'd95040;
                3'd6:    s = 20'd665280;
                default: s = 20'd1;
            endcase
        end else begin
            case (n)
                3'd1:    s = 20'd8;
                3'd2:    s = 20'd56;
                3'd3:    s = 20'd336;
                3'd4:    s = 20'd1680;
                3'd5:    s = 20'd6720;
                3'd6:    s = 20'd20160;
                default: s = 20'd1;
            endcase
        end
        return s;
    endfunction

    // c to the power k, c is 2 or 3, k in 0..6.
    function automatic logic [9:0] ori_pow(input logic [1:0] c, input logic [2:0] k);
        logic [9:0] p;
        p = 10'd1;
        if (c == 2'd3) begin
            case (k)
                3'd1:    p = 10'd3;
                3'd2:    p = 10'd9;
                3'd3:    p = 10'd27;
                3'd4:    p = 10'd81;
                3'd5:    p = 10'd243;
                3'd6:    p = 10'd729;
                default: p = 10'd1;
            endcase
        end else begin
            p = 10'(10'd1 << k);
        end
        return p;
    endfunction

    // ceil(2^33 / d): exact quotient for any 29-bit dividend, d in 3..12.
    function automatic logic [31:0] div_magic(input logic [3:0] d);
        logic [31:0] m;
        case (d)
            4'd3:    m = 32'd2863311531;
            4'd4:    m = 32'd2147483648;
            4'd5:    m = 32'd1717986919;
            4'd6:    m = 32'd1431655766;
            4'd7:    m = 32'd1227133514;
            4'd8:    m = 32'd1073741824;
            4'd9:    m = 32'd954437177;
            4'd10:   m = 32'd858993460;
            4'd11:   m = 32'd780903145;
            4'd12:   m = 32'd715827883;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/partial_permutation_orientation_rank.sv =====
`timescale 1ns / 1ps
// Top level: config registers, rank/unrank pipeline and output register.
//
//   channel | direction | handshake           | payload
//   s_      | in        | s_valid / s_ready   | s_data  (req_t)
//   m_      | out       | m_valid / m_ready   | m_data  (rsp_t)
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle unless m_ready stalls; the path holds 5 rank stages, 12
// two-stage divide steps, 6 position select stages and the output register.
// The 29x32 reciprocal multiply in each divide step sets the stage depth.
// Reset clears all valid bits and loads the default configuration.
// A stall at m_ready freezes every stage at once; s_ready follows it.
module partial_permutation_orientation_rank #(
    parameter int MAX_PIECES = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ppor_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ppor_pkg::rsp_t   m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [2:0]       cfg_data
);
    import ppor_pkg::*;

    localparam int         NSTAGE          = 2 * PIECES + PIECES + 1;

    logic [2:0]  piece_count_reg;
    logic [1:0]  orientation_count_reg;
    logic        large_universe_reg;
    cfg_t        cfg;
    logic        en;

    logic [NSTAGE-1:0] chain_valid;
    work_t             chain_work [NSTAGE];

    logic        out_valid_reg;
    rsp_t        out_data_reg;
    rsp_t        rsp_next;
    work_t       fin;
    logic [PIECES-1:0][5:0] pc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piece_count_reg       <= 3'd4;
            orientation_count_reg <= 2'd2;
            large_universe_reg    <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PIECE_COUNT: piece_count_reg       <= cfg_data;
                CFG_ORIENT:      orientation_count_reg <= cfg_data[1:0];
                CFG_LARGE:       large_universe_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (piece_count_reg == 3'd0) begin
            cfg.n = 3'd1;
        end else if (32'(piece_count_reg) > MAX_PIECES) begin
            cfg.n = 3'(MAX_PIECES);
        end else begin
            cfg.n = piece_count_reg;
        end
        cfg.c     = (orientation_count_reg < 2'd2) ? 2'd2 : orientation_count_reg;
        cfg.npos  = large_universe_reg ? 4'd12 : 4'd8;
        cfg.space = VAL_W'(30'(perm_space(large_universe_reg, cfg.n))
                           * 30'(ori_pow(cfg.c, cfg.n)));
    end

    // Advance the whole pipeline unless the output item is held.
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    ppor_rank u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_req    (s_data),
        .cfg       (cfg),
        .out_valid (chain_valid[0]),
        .out_work  (chain_work[0])
    );

    for (genvar k = 0; k < 2 * PIECES; k++) begin : g_div
        ppor_div_step #(.STEP(k)) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[k]),
            .in_work   (chain_work[k]),
            .cfg       (cfg),
            .out_valid (chain_valid[k+1]),
            .out_work  (chain_work[k+1])
        );
    end

    for (genvar s = 0; s < PIECES; s++) begin : g_sel
        ppor_select #(.STEP(s)) u_sel (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[2*PIECES+s]),
            .in_work   (chain_work[2*PIECES+s]),
            .cfg       (cfg),
            .out_valid (chain_valid[2*PIECES+s+1]),
            .out_work  (chain_work[2*PIECES+s+1])
        );
    end

    assign fin = chain_work[NSTAGE-1];

    always_comb begin
        for (int i = 0; i < PIECES; i++) begin
            pc[i] = '0;
            if (fin.unrank && !fin.err && (3'(i) < cfg.n)) begin
                pc[i] = 6'({2'b00, fin.dig[i]} * {4'b0000, cfg.c}) + {4'b0000, fin.ori[i]};
            end
        end
        rsp_next.index_out   = (fin.unrank || fin.err) ? '0 : fin.rank_idx;
        rsp_next.out_piece_0 = pc[0];
        rsp_next.out_piece_1 = pc[1];
        rsp_next.out_piece_2 = pc[2];
        rsp_next.out_piece_3 = pc[3];
        rsp_next.out_piece_4 = pc[4];
        rsp_next.out_piece_5 = pc[5];
        rsp_next.error       = fin.err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= chain_valid[NSTAGE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= rsp_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== hdl/ppor_rank.sv =====
`timescale 1ns / 1ps
// Five-stage rank front end: piece decode, Lehmer digits, weighting, sum, final scale.
module ppor_rank (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  ppor_pkg::req_t   in_req,
    input  ppor_pkg::cfg_t   cfg,
    output logic             out_valid,
    output ppor_pkg::work_t  out_work
);
    import ppor_pkg::*;

    logic [PIECES-1:0][5:0] pc;
    logic [PIECES-1:0][4:0] pos_next;
    logic [PIECES-1:0][1:0] ori_next;
    logic [11:0]            q3 [PIECES];
    logic [5:0]             qc [PIECES];
    logic                   univ12;

    // stage 1
    logic                   s1_valid_reg;
    logic                   s1_unrank_reg;
    logic                   s1_uerr_reg;
    logic [VAL_W-1:0]       s1_index_reg;
    logic [PIECES-1:0][4:0] s1_pos_reg;
    logic [PIECES-1:0][1:0] s1_ori_reg;
    // stage 2
    logic                   s2_valid_reg;
    logic                   s2_unrank_reg;
    logic                   s2_err_reg;
    logic [VAL_W-1:0]       s2_index_reg;
    logic [PIECES-1:0][3:0] s2_dig_reg;
    logic [9:0]             s2_idxo_reg;
    logic                   rerr;
    logic [PIECES-1:0][3:0] dig_next;
    logic [9:0]             idxo_next;
    logic [2:0]             cnt;
    logic [2:0]             expo;
    logic                   act_i;
    // stage 3
    logic                   s3_valid_reg;
    logic                   s3_unrank_reg;
    logic                   s3_err_reg;
    logic [VAL_W-1:0]       s3_index_reg;
    logic [19:0]            s3_prod_reg [PIECES];
    logic [9:0]             s3_idxo_reg;
    // stage 4
    logic                   s4_valid_reg;
    logic                   s4_unrank_reg;
    logic                   s4_err_reg;
    logic [VAL_W-1:0]       s4_index_reg;
    logic [19:0]            s4_idxp_reg;
    logic [9:0]             s4_idxo_reg;
    logic [19:0]            idxp_next;
    // stage 5
    logic                   s5_valid_reg;
    work_t                  s5_work_reg;

    assign univ12 = (cfg.npos == 4'd12);
    assign pc[0] = in_req.in_piece_0;
    assign pc[1] = in_req.in_piece_1;
    assign pc[2] = in_req.in_piece_2;
    assign pc[3] = in_req.in_piece_3;
    assign pc[4] = in_req.in_piece_4;
    assign pc[5] = in_req.in_piece_5;

    // Split codes into position and orientation; divide by 3 as (x * 43) >> 7.
    always_comb begin
        for (int i = 0; i < PIECES; i++) begin
            q3[i] = 12'(pc[i]) * 12'd43;
            qc[i] = (cfg.c == 2'd3) ? {1'b0, q3[i][11:7]} : (pc[i] >> 1);
            pos_next[i] = qc[i][4:0];
            ori_next[i] = 2'(pc[i][1:0] - 2'(qc[i][1:0] * cfg.c));
        end
    end

    always_comb begin
        rerr      = 1'b0;
        idxo_next = '0;
        dig_next  = '0;
        cnt       = '0;
        expo      = '0;
        act_i     = 1'b0;
        for (int i = 0; i < PIECES; i++) begin
            act_i = (3'(i) < cfg.n);
            cnt   = '0;
            for (int j = 0; j < i; j++) begin
                if (s1_pos_reg[j] == s1_pos_reg[i]) begin
                    rerr = rerr | act_i;
                end
                if (s1_pos_reg[j] < s1_pos_reg[i]) begin
                    cnt = cnt + 3'd1;
                end
            end
            if (act_i) begin
                if (s1_pos_reg[i] >= {1'b0, cfg.npos}) begin
                    rerr = 1'b1;
                end
                expo        = 3'(cfg.n - 3'(i) - 3'd1);
                dig_next[i] = 4'(s1_pos_reg[i] - 5'(cnt));
                idxo_next   = idxo_next + 10'(s1_ori_reg[i] * ori_pow(cfg.c, expo));
            end
        end
    end

    always_comb begin
        idxp_next = '0;
        for (int i = 0; i < PIECES; i++) begin
            idxp_next = idxp_next + s3_prod_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_unrank_reg <= (in_req.req_type == REQ_UNRANK);
            s1_uerr_reg   <= (in_req.index_in >= cfg.space);
            s1_index_reg  <= in_req.index_in;
            s1_pos_reg    <= pos_next;
            s1_ori_reg    <= ori_next;

            s2_unrank_reg <= s1_unrank_reg;
            s2_err_reg    <= s1_unrank_reg ? s1_uerr_reg : rerr;
            s2_index_reg  <= s1_index_reg;
            s2_dig_reg    <= dig_next;
            s2_idxo_reg   <= idxo_next;

            s3_unrank_reg <= s2_unrank_reg;
            s3_err_reg    <= s2_err_reg;
            s3_index_reg  <= s2_index_reg;
            s3_idxo_reg   <= s2_idxo_reg;
            for (int i = 0; i < PIECES; i++) begin
                s3_prod_reg[i] <= 20'(20'(s2_dig_reg[i]) * 20'(lehmer_weight(univ12, 3'(i))));
            end

            s4_unrank_reg <= s3_unrank_reg;
            s4_err_reg    <= s3_err_reg;
            s4_index_reg  <= s3_index_reg;
            s4_idxp_reg   <= idxp_next;
            s4_idxo_reg   <= s3_idxo_reg;

            s5_work_reg.unrank   <= s4_unrank_reg;
            s5_work_reg.err      <= s4_err_reg;
            s5_work_reg.val      <= s4_index_reg;
            s5_work_reg.rank_idx <= VAL_W'(30'(s4_idxp_reg) * 30'(ori_pow(cfg.c, cfg.n))
                                          + 30'(s4_idxo_reg));
            s5_work_reg.ori      <= '0;
            s5_work_reg.dig      <= '0;
            s5_work_reg.used     <= '0;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_work  = s5_work_reg;

endmodule

// ===== hdl/ppor_div_step.sv =====
`timescale 1ns / 1ps
// Two-stage divide step: peels one orientation or Lehmer digit off the index.
module ppor_div_step #(
    parameter int STEP = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  ppor_pkg::work_t  in_work,
    input  ppor_pkg::cfg_t   cfg,
    output logic             out_valid,
    output ppor_pkg::work_t  out_work
);
    import ppor_pkg::*;

    localparam bit         IS_ORI = (STEP < PIECES);
    localparam logic [2:0] SUB    = 3'(STEP % PIECES);

    logic [3:0]        d;
    logic              act;
    logic [60:0]       prod;
    logic [2:0]        oidx;
    logic [VAL_W-1:0]  q;
    logic [7:0]        qd;
    logic [3:0]        r;
    work_t             b_next;

    logic              a_valid_reg;
    work_t             a_work_reg;
    logic [27:0]       a_hi_reg;
    logic              b_valid_reg;
    work_t             b_work_reg;

    assign d    = IS_ORI ? {2'b00, cfg.c} : 4'(cfg.npos - {1'b0, SUB});
    assign act  = (SUB < cfg.n);
    assign oidx = 3'(cfg.n - SUB - 3'd1);
    assign prod = 61'(in_work.val) * 61'(div_magic(d));

    always_comb begin
        q  = (d == 4'd2) ? (a_work_reg.val >> 1) : {1'b0, a_hi_reg};
        qd = {4'b0000, q[3:0]} * {4'b0000, d};
        r  = a_work_reg.val[3:0] - qd[3:0];
        b_next = a_work_reg;
        if (a_work_reg.unrank && act) begin
            b_next.val = q;
            if (IS_ORI) begin
                b_next.ori[oidx] = r[1:0];
            end else begin
                b_next.dig[SUB] = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_work_reg <= in_work;
            a_hi_reg   <= prod[60:MAGIC_SHIFT];
            b_work_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_work  = b_work_reg;

endmodule

// ===== hdl/ppor_select.sv =====
`timescale 1ns / 1ps
// One pipeline stage that turns a Lehmer digit into the matching free position.
module ppor_select #(
    parameter int STEP = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  ppor_pkg::work_t  in_work,
    input  ppor_pkg::cfg_t   cfg,
    output logic             out_valid,
    output ppor_pkg::work_t  out_work
);
    import ppor_pkg::*;

    localparam logic [2:0] SUB = 3'(STEP);

    logic [11:0] hit;
    logic [11:0] lowmask;
    logic [3:0]  pos;
    work_t       next;
    logic        valid_reg;
    work_t       work_reg;

    always_comb begin
        hit     = '0;
        lowmask = '0;
        pos     = '0;
        for (int p = 0; p < 12; p++) begin
            lowmask = 12'((13'd1 << p) - 13'd1);
            hit[p]  = !in_work.used[p] && (4'(p) < cfg.npos)
                      && (4'($countones(~in_work.used & lowmask)) == in_work.dig[SUB]);
        end
        for (int p = 0; p < 12; p++) begin
            if (hit[p]) begin
                pos = 4'(p);
            end
        end
        next = in_work;
        if (in_work.unrank && (SUB < cfg.n)) begin
            next.dig[SUB] = pos;
            next.used     = in_work.used | hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg <= next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ===== tb/sv/partial_permutation_orientation_rank_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the coordinate rank/unrank pipeline with random flow control.
module partial_permutation_orientation_rank_tb;
    import ppor_pkg::*;

    localparam int LATENCY   = 36;
    localparam int MAX_CYCLES = 400000;
    localparam int REQ_W     = $bits(req_t);

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    req_t       s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    rsp_t       m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [2:0] cfg_data = '0;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    int   cycles = 0;
    int   accepted = 0;
    int   checked = 0;
    int   ranks = 0;
    int   unranks = 0;
    int   flagged = 0;
    int   hold_off = 0;
    bit   calm = 1'b0;
    bit   stall_req = 1'b0;
    logic [2:0] cur_pieces = 3'd4;
    logic [1:0] cur_orient = 2'd2;
    logic       cur_large = 1'b1;

    partial_permutation_orientation_rank u_top (.*);

    always #10 aclk = ~aclk;

    task automatic enqueue_req(input req_t r);
        pending_reqs = {pending_reqs, r};
    endtask

    function automatic logic [5:0] get_piece(input req_t r, input int i);
        case (i)
            0: return r.in_piece_0;
            1: return r.in_piece_1;
            2: return r.in_piece_2;
            3: return r.in_piece_3;
            4: return r.in_piece_4;
            default: return r.in_piece_5;
        endcase
    endfunction

    function automatic rsp_t convert_coord(input req_t r);
        rsp_t o;
        int n, c, npos, cpow, pspace, used, ip, io, w, pos, ori, below, dig, seen;
        int posv[6];
        longint idx;
        o = '0;
        n = cur_pieces;
        if (n < 1) n = 1;
        if (n > 6) n = 6;
        c = (cur_orient < 2) ? 2 : cur_orient;
        npos = cur_large ? 12 : 8;
        cpow = 1;
        pspace = 1;
        for (int i = 0; i < n; i++) begin
            cpow *= c;
            pspace *= npos - i;
        end
        used = 0;
        if (r.req_type == REQ_RANK) begin
            ip = 0; io = 0; w = 1;
            for (int i = 0; i < n; i++) begin
                pos = get_piece(r, i) / c;
                ori = get_piece(r, i) % c;
                if (pos >= npos || used[pos]) begin
                    o.error = 1'b1;
                    return o;
                end
                below = 0;
                for (int k = 0; k < pos; k++) below += used[k];
                ip += (pos - below) * w;
                w *= npos - i;
                used |= 1 << pos;
                io = io * c + ori;
            end
            o.index_out = VAL_W'(ip * cpow + io);
        end else begin
            idx = r.index_in;
            if (idx >= longint'(pspace) * cpow) begin
                o.error = 1'b1;
                return o;
            end
            ip = int'(idx / cpow);
            io = int'(idx % cpow);
            for (int i = 0; i < n; i++) begin
                dig = ip % (npos - i);
                ip /= npos - i;
                seen = 0;
                for (pos = 0; pos < npos; pos++) begin
                    if (used[pos]) continue;
                    if (seen == dig) break;
                    seen++;
                end
                if (pos >= npos) pos = npos - 1;
                used |= 1 << pos;
                posv[i] = pos;
            end
            for (int i = n - 1; i >= 0; i--) begin
                ori = io % c;
                io /= c;
                case (i)
                    0: o.out_piece_0 = 6'(posv[i] * c + ori);
                    1: o.out_piece_1 = 6'(posv[i] * c + ori);
                    2: o.out_piece_2 = 6'(posv[i] * c + ori);
                    3: o.out_piece_3 = 6'(posv[i] * c + ori);
                    4: o.out_piece_4 = 6'(posv[i] * c + ori);
                    default: o.out_piece_5 = 6'(posv[i] * c + ori);
                endcase
            end
        end
        return o;
    endfunction

    // Distinct positions, random orientations; legal for the current setting.
    function automatic req_t legal_rank();
        req_t r;
        int c, npos, p, used;
        logic [5:0] code;
        r = '0;
        r.req_type = REQ_RANK;
        r.index_in = VAL_W'($urandom);
        c = (cur_orient < 2) ? 2 : cur_orient;
        npos = cur_large ? 12 : 8;
        used = 0;
        for (int i = 0; i < 6; i++) begin
            do p = $urandom_range(npos - 1); while (used[p] && i < npos);
            used |= 1 << p;
            code = 6'(p * c + $urandom_range(c - 1));
            case (i)
                0: r.in_piece_0 = code;
                1: r.in_piece_1 = code;
                2: r.in_piece_2 = code;
                3: r.in_piece_3 = code;
                4: r.in_piece_4 = code;
                default: r.in_piece_5 = code;
            endcase
        end
        return r;
    endfunction

    function automatic req_t random_req();
        req_t r;
        int n, c, space;
        n = (cur_pieces < 1) ? 1 : (cur_pieces > 6 ? 6 : cur_pieces);
        c = (cur_orient < 2) ? 2 : cur_orient;
        space = 1;
        for (int i = 0; i < n; i++) space *= (cur_large ? 12 : 8) - i;
        for (int i = 0; i < n; i++) space *= c;
        case ($urandom_range(9))
            0, 1, 2, 3: r = legal_rank();
            4, 5, 6, 7: begin
                r = legal_rank();
                r.req_type = REQ_UNRANK;
                r.index_in = VAL_W'($urandom_range(space - 1));
            end
            8: begin
                r = req_t'(REQ_W'({$urandom, $urandom, $urandom}));
                r.req_type = REQ_RANK;
            end
            default: begin
                r = req_t'(REQ_W'({$urandom, $urandom, $urandom}));
                r.req_type = REQ_UNRANK;
                if ($urandom_range(1)) r.index_in = VAL_W'(space + $urandom_range(3));
            end
        endcase
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PIECE_COUNT: cur_pieces = val;
            CFG_ORIENT:      cur_orient = val[1:0];
            default:         cur_large = val[0];
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [2:0] n, input logic [1:0] c, input logic l);
        wait_drained();
        write_reg(CFG_PIECE_COUNT, n);
        write_reg(CFG_ORIENT, {1'b0, c});
        write_reg(CFG_LARGE, {2'b0, l});
    endtask

    // Driver: offer the next item, hold it until accepted.
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            accepted <= accepted + 1;
            expected_rsps = {expected_rsps, convert_coord(s_data)};
            if (s_data.req_type == REQ_RANK) ranks <= ranks + 1;
            else unranks <= unranks + 1;
        end
        if (!s_valid || s_ready) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
                s_valid <= 1'b1;
                s_data  <= pending_reqs.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest expectation and drive m_ready.
    always @(posedge aclk) begin
        rsp_t exp_rsp;
        if (m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, m_data);
                errors <= errors + 1;
            end else begin
                exp_rsp = expected_rsps.pop_front();
                checked <= checked + 1;
                if (exp_rsp.error) flagged <= flagged + 1;
                if (exp_rsp !== m_data) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_rsp, m_data);
                    errors <= errors + 1;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 1'b0;
        end else if (stall_req) begin
            hold_off <= 200;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= calm || $urandom_range(99) >= 24;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        req_t r;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults first, then directed cases.
        r = '0;
        enqueue_req(r);
        r.req_type = REQ_UNRANK;
        enqueue_req(r);
        r.index_in = VAL_W'(11880 * 16 - 1);
        enqueue_req(r);
        r.index_in = VAL_W'(11880 * 16);
        enqueue_req(r);
        r.index_in = '1;
        enqueue_req(r);
        r = '0;
        r.in_piece_0 = 6'd23; r.in_piece_1 = 6'd20; r.in_piece_2 = 6'd1; r.in_piece_3 = 6'd10;
        enqueue_req(r);
        r.in_piece_1 = 6'd22;                      // same position as piece 0
        enqueue_req(r);
        r.in_piece_1 = 6'd24;                      // outside the universe
        enqueue_req(r);
        r.in_piece_1 = 6'h3f;
        r.in_piece_4 = 6'h3f; r.in_piece_5 = 6'h3f; // ignored beyond n
        enqueue_req(r);

        set_config(3'd6, 2'd3, 1'b1);
        r = '0;
        r.req_type = REQ_UNRANK;
        r.index_in = VAL_W'(665280 * 729 - 1);
        enqueue_req(r);
        r.index_in = VAL_W'(665280 * 729);
        enqueue_req(r);
        r = '0;
        r.in_piece_0 = 6'd35; r.in_piece_1 = 6'd32; r.in_piece_2 = 6'd29;
        r.in_piece_3 = 6'd26; r.in_piece_4 = 6'd23; r.in_piece_5 = 6'd20;
        enqueue_req(r);

        set_config(3'd0, 2'd0, 1'b0);   // clamps to one piece, two orientations
        r = '0;
        r.req_type = REQ_UNRANK;
        r.index_in = VAL_W'(15);
        enqueue_req(r);
        r.index_in = VAL_W'(16);
        enqueue_req(r);
        r = '0;
        r.in_piece_0 = 6'd15;
        enqueue_req(r);
        r.in_piece_0 = 6'd16;
        enqueue_req(r);

        set_config(3'd7, 2'd1, 1'b0);
        for (int k = 0; k < 20; k++) enqueue_req(random_req());

        // Random phases over several settings, one with a long receiver hold-off.
        for (int ph = 0; ph < 6; ph++) begin
            set_config(3'($urandom_range(7)), 2'($urandom_range(3)), 1'($urandom_range(1)));
            calm = (ph == 2);
            for (int k = 0; k < 85; k++) enqueue_req(random_req());
            if (ph == 4) begin
                stall_req = 1'b1;
                wait (hold_off > 0);
                stall_req = 1'b0;
            end
        end
        calm = 1'b0;
        wait_drained();

        $display("accepted %0d items (%0d rank, %0d unrank), checked %0d results, %0d flagged",
                 accepted, ranks, unranks, checked, flagged);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ppor_pkg.sv
hdl/ppor_rank.sv
hdl/ppor_div_step.sv
hdl/ppor_select.sv
hdl/partial_permutation_orientation_rank.sv
tb/sv/partial_permutation_orientation_rank_tb.sv
